FILE: rtl/assert_macros.svh
// Assertion helper macros for the atlas allocator checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// Next-cycle implication checked outside reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

FILE: rtl/rab_pkg.sv
// ----------------------------------------------------------------------------
// rab_pkg
// Shared types and constants of the rectangle atlas allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package rab_pkg;
   localparam int unsigned SIDE_BITS = 7;
   typedef logic [1:0] action_type;
   localparam action_type ACT_MARK   = 2'd0;
   localparam action_type ACT_UNMARK = 2'd1;
   localparam action_type ACT_FIND   = 2'd2;
   localparam action_type ACT_EXTENT = 2'd3;
   typedef logic [1:0] status_type;
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_BOUNDS = 2'd1;
   localparam status_type ST_NOROOM = 2'd2;
   localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
endpackage
`default_nettype wire

FILE: rtl/rab_row_store.sv
// ----------------------------------------------------------------------------
// rab_row_store
// Occupancy row memory: one word per atlas row, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module rab_row_store #(
   parameter int unsigned SIDE = 64,
   parameter int unsigned AW   = 6
) (
   input  wire logic            clock,
   input  wire logic [AW-1:0]   rd_addr,
   output logic      [SIDE-1:0] rd_data,
   input  wire logic            wr_en,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire logic [SIDE-1:0] wr_data
);
   logic [SIDE-1:0] mem [SIDE];
   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/rect_atlas_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// rect_atlas_bitmap_allocator
// First-fit rectangle allocator over a one-bit occupancy map.
// ----------------------------------------------------------------------------
//  channel | ports                         | handshake
//  request | req_action/x/y/w/h            | start & !busy
//  result  | rsp_status/found/used         | rsp_valid, one cycle
//  config  | csr_wr_en/csr_index/csr_wdata | csr_wr_en, no wait
// Reset: a clearing pass sweeps all MAX_SIDE rows, busy high.
// Mark/unmark: per row of the rectangle, a read and then a modify-write.
// Extent: pipelined reads of every map row. Find: per start row, reads of
// its h rows, then one column tested at a time, then a step to the next row.
// The single row memory serves every action. Results cannot stall.
`default_nettype none
module rect_atlas_bitmap_allocator #(
   parameter int unsigned MAX_SIDE = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_action,
   input  wire logic [5:0]                 req_rect_x,
   input  wire logic [5:0]                 req_rect_y,
   input  wire logic [6:0]                 req_rect_w,
   input  wire logic [6:0]                 req_rect_h,
   output logic                            rsp_valid,
   output rab_pkg::status_type             rsp_status,
   output logic [5:0]                      rsp_found_x,
   output logic [5:0]                      rsp_found_y,
   output logic [6:0]                      rsp_used_width,
   output logic [6:0]                      rsp_used_height,
   input  wire logic                       csr_wr_en,
   input  wire logic                       csr_index,
   input  wire logic [6:0]                 csr_wdata
);
   import rab_pkg::*;
   localparam int unsigned AW = $clog2(MAX_SIDE);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001, S_IDLE = 8'b0000_0010, S_MRD = 8'b0000_0100,
      S_MWR   = 8'b0000_1000, S_FRD  = 8'b0001_0000, S_FCOL = 8'b0010_0000,
      S_XRD   = 8'b0100_0000, S_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] mw_ff, mw_in, mh_ff, mh_in;
   logic [1:0] act_ff, act_in;
   logic [6:0] x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic [7:0] r_ff, r_in;        // current row / start row
   logic [7:0] k_ff, k_in;        // row being read, or offset from the start row in find
   logic [6:0] c_ff, c_in;        // column
   logic [MAX_SIDE-1:0] acc_ff, acc_in;
   logic [6:0] uh_ff, uh_in;
   logic       pend_ff, pend_in;  // read data arrives next cycle
   logic [7:0] pk_ff, pk_in;      // row of that pending read
   logic       rv_ff, rv_in;
   status_type st_ff, st_in;
   logic [5:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [6:0] uw_ff, uw_in, ohh_ff, ohh_in;

   logic [AW-1:0]       rd_addr, wr_addr;
   logic [MAX_SIDE-1:0] rd_data, wr_data;
   logic                wr_en;

   rab_row_store #(.SIDE(MAX_SIDE), .AW(AW)) u_store (
      .clock(clock), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   logic [6:0] mw_c, mh_c;
   logic [MAX_SIDE-1:0] wmask, rmask, win;
   logic [7:0] sum_x, sum_y;

   function automatic logic [MAX_SIDE-1:0] ones(input logic [6:0] n);
      logic [MAX_SIDE-1:0] v;
      v = '0;
      for (int i = 0; i < MAX_SIDE; i++) begin
         v[i] = (8'(i) < {1'b0, n});
      end
      return v;
   endfunction

   always_comb begin
      mw_c = (mw_ff > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : mw_ff;
      mh_c = (mh_ff > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : mh_ff;
      wmask = ones(mw_c);
      rmask = ones(w_ff) << x_ff[5:0];
      win   = acc_ff >> c_ff;
      sum_x = {1'b0, x_ff} + {1'b0, w_ff};
      sum_y = {1'b0, y_ff} + {1'b0, h_ff};
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rv_ff;
   assign rsp_status      = st_ff;
   assign rsp_found_x     = fx_ff;
   assign rsp_found_y     = fy_ff;
   assign rsp_used_width  = uw_ff;
   assign rsp_used_height = ohh_ff;

   // sequencer: one row memory shared by every action
   always_comb begin
      state_in = state_ff; mw_in = mw_ff; mh_in = mh_ff; act_in = act_ff;
      x_in = x_ff; y_in = y_ff; w_in = w_ff; h_in = h_ff;
      r_in = r_ff; k_in = k_ff; c_in = c_ff; acc_in = acc_ff; uh_in = uh_ff;
      pend_in = 1'b0; pk_in = pk_ff;
      rv_in = 1'b0; st_in = st_ff; fx_in = fx_ff; fy_in = fy_ff;
      uw_in = uw_ff; ohh_in = ohh_ff;
      rd_addr = k_ff[AW-1:0]; wr_en = 1'b0; wr_addr = r_ff[AW-1:0];
      wr_data = rd_data;
      if (csr_wr_en) begin
         if (csr_index == CFG_MAP_WIDTH[0]) mw_in = csr_wdata;
         else mh_in = csr_wdata;
      end
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1; wr_data = '0;
            r_in = r_ff + 8'd1;
            if (r_ff == 8'(MAX_SIDE - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               act_in = req_action; x_in = {1'b0, req_rect_x};
               y_in = {1'b0, req_rect_y}; w_in = req_rect_w; h_in = req_rect_h;
               st_in = ST_OK; fx_in = '0; fy_in = '0; uw_in = '0; ohh_in = '0;
               r_in = {2'b0, req_rect_y}; k_in = '0; c_in = '0; acc_in = '0;
               case (req_action)
                  ACT_MARK, ACT_UNMARK: state_in = S_MRD;
                  ACT_FIND: begin
                     // search from the top row
                     state_in = S_FRD; r_in = '0;
                  end
                  default: begin
                     state_in = S_XRD; uh_in = '0;
                  end
               endcase
            end
         end
         S_MRD: begin
            if (sum_x > {1'b0, mw_c} || sum_y > {1'b0, mh_c}) begin
               st_in = ST_BOUNDS; state_in = S_DONE;
            end else if (r_ff >= sum_y) begin
               state_in = S_DONE;
            end else begin
               rd_addr = r_ff[AW-1:0]; state_in = S_MWR;
            end
         end
         S_MWR: begin
            wr_en = 1'b1;
            wr_data = (act_ff == ACT_MARK) ? (rd_data | rmask) : (rd_data & ~rmask);
            r_in = r_ff + 8'd1; state_in = S_MRD;
         end
         S_FRD: begin
            // gather OR of rows r..r+h-1, one read per cycle
            if (w_ff > mw_c || h_ff > mh_c) begin
               st_in = ST_BOUNDS; state_in = S_DONE;
            end else if ({1'b0, r_ff} + {2'b0, h_ff} > {2'b0, mh_c}) begin
               st_in = ST_NOROOM; state_in = S_DONE;
            end else begin
               if (pend_ff) acc_in = acc_ff | rd_data;
               if (k_ff < {1'b0, h_ff}) begin
                  rd_addr = AW'(r_ff + k_ff);
                  pend_in = 1'b1; k_in = k_ff + 8'd1;
               end else if (!pend_ff) begin
                  acc_in = acc_ff & wmask; c_in = '0; state_in = S_FCOL;
               end
            end
         end
         S_FCOL: begin
            if ({1'b0, c_ff} + {1'b0, w_ff} > {1'b0, mw_c}) begin
               r_in = r_ff + 8'd1; k_in = '0; acc_in = '0; state_in = S_FRD;
            end else if ((win & ones(w_ff)) == '0) begin
               fx_in = c_ff[5:0]; fy_in = r_ff[5:0]; state_in = S_DONE;
            end else begin
               c_in = c_ff + 7'd1;
            end
         end
         S_XRD: begin
            if (pend_ff) begin
               acc_in = acc_ff | (rd_data & wmask);
               if ((rd_data & wmask) != '0) uh_in = 7'(pk_ff + 8'd1);
            end
            if (k_ff < {1'b0, mh_c}) begin
               rd_addr = k_ff[AW-1:0]; pend_in = 1'b1; pk_in = k_ff;
               k_in = k_ff + 8'd1;
            end else if (!pend_ff) begin
               ohh_in = mh_c; uw_in = mw_c;
               if (acc_ff != '0) begin
                  ohh_in = uh_ff;
                  for (int i = 0; i < MAX_SIDE; i++) begin
                     if (acc_ff[i]) uw_in = 7'(i + 1);
                  end
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; r_ff <= '0; mw_ff <= 7'd64; mh_ff <= 7'd64;
         rv_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; r_ff <= r_in; mw_ff <= mw_in; mh_ff <= mh_in;
         rv_ff <= rv_in; pend_ff <= pend_in;
      end
      act_ff <= act_in; x_ff <= x_in; y_ff <= y_in; w_ff <= w_in; h_ff <= h_in;
      k_ff <= k_in; c_ff <= c_in; acc_ff <= acc_in; uh_ff <= uh_in;
      pk_ff <= pk_in; st_ff <= st_in; fx_ff <= fx_in; fy_ff <= fy_in;
      uw_ff <= uw_in; ohh_ff <= ohh_in;
   end
endmodule
`default_nettype wire

FILE: rtl/rab_checker.sv
// ----------------------------------------------------------------------------
// rab_checker
// Port-level checks of the atlas allocator, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rab_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_status,
   input wire logic [5:0] rsp_found_x,
   input wire logic [5:0] rsp_found_y
);
   import rab_pkg::*;
   // a request raises busy
   `CHK_NEXT(a_take, clock, reset, start && !busy, busy)
   // a result comes once the busy period has ended
   `CHK_IMPL(a_free, clock, reset, rsp_valid, !busy)
   // results come only just after a busy period
   `CHK_IMPL(a_resp, clock, reset, rsp_valid, $past(busy))
   // a failed request reports the origin
   `CHK_IMPL(a_zero, clock, reset, rsp_valid && rsp_status != ST_OK,
      rsp_found_x == 6'd0 && rsp_found_y == 6'd0)
endmodule
bind rect_atlas_bitmap_allocator rab_checker u_rab_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_found_x(rsp_found_x), .rsp_found_y(rsp_found_y)
);
`default_nettype wire

FILE: tb/rect_atlas_bitmap_allocator_tb.sv
// ----------------------------------------------------------------------------
// rect_atlas_bitmap_allocator_tb
// Drives mark, unmark, find and extent requests into the allocator under a
// range of map sizes. A local occupancy model predicts every result, and a
// checker compares each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rect_atlas_bitmap_allocator_tb;
   import rab_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [5:0]  found_x;
      logic [5:0]  found_y;
      logic [6:0]  used_width;
      logic [6:0]  used_height;
   } alloc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = ACT_EXTENT;
   logic [5:0]  req_rect_x = '0;
   logic [5:0]  req_rect_y = '0;
   logic [6:0]  req_rect_w = '0;
   logic [6:0]  req_rect_h = '0;
   logic        rsp_valid;
   status_type  rsp_status;
   logic [5:0]  rsp_found_x;
   logic [5:0]  rsp_found_y;
   logic [6:0]  rsp_used_width;
   logic [6:0]  rsp_used_height;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [6:0]  csr_wdata = '0;

   rect_atlas_bitmap_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_rect_x(req_rect_x), .req_rect_y(req_rect_y),
      .req_rect_w(req_rect_w), .req_rect_h(req_rect_h),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_found_x(rsp_found_x), .rsp_found_y(rsp_found_y),
      .rsp_used_width(rsp_used_width), .rsp_used_height(rsp_used_height),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model state and pending results
   logic [63:0]      occ_rows [0:63];
   logic [6:0]       atlas_w = 7'd64;
   logic [6:0]       atlas_h = 7'd64;
   alloc_result_type pending_results [$];
   int               error_count = 0;
   int               burst_left = 0;

   function automatic logic [63:0] ones_below(int n);
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   // compute one result and apply the request to the occupancy model
   function automatic alloc_result_type predict_alloc(logic [1:0] act, int x, int y,
                                                      int w, int h);
      alloc_result_type res;
      int mw, mh, r, k, c, uw, uh;
      logic [63:0] wmask, acc, bits;
      res = '0;
      mw = (atlas_w > 64) ? 64 : atlas_w;
      mh = (atlas_h > 64) ? 64 : atlas_h;
      wmask = ones_below(mw);
      if (act == ACT_MARK || act == ACT_UNMARK) begin
         if (x + w > mw || y + h > mh) begin
            res.status = ST_BOUNDS;
         end else begin
            bits = ones_below(w) << x;
            for (r = y; r < y + h && r < 64; r++)
               occ_rows[r] = (act == ACT_MARK) ? (occ_rows[r] | bits)
                                               : (occ_rows[r] & ~bits);
         end
      end else if (act == ACT_FIND) begin
         if (w > mw || h > mh) begin
            res.status = ST_BOUNDS;
         end else begin
            res.status = ST_NOROOM;
            for (r = 0; r + h <= mh && res.status == ST_NOROOM; r++) begin
               acc = '0;
               for (k = r; k < r + h && k < 64; k++) acc |= occ_rows[k];
               acc &= wmask;
               for (c = 0; c + w <= mw; c++) begin
                  if (((acc >> c) & ones_below(w)) == '0) begin
                     res.status = ST_OK;
                     res.found_x = c[5:0];
                     res.found_y = r[5:0];
                     break;
                  end
               end
            end
         end
      end else begin
         uh = mh;
         uw = mw;
         for (r = mh; r > 0; r--) begin
            if ((occ_rows[r-1] & wmask) != '0) begin
               uh = r;
               break;
            end
         end
         acc = '0;
         for (r = 0; r < mh; r++) acc |= occ_rows[r];
         acc &= wmask;
         if (acc != '0) begin
            for (c = 64; c > 0; c--) begin
               if (acc[c-1]) begin
                  uw = c;
                  break;
               end
            end
         end
         res.used_width = uw[6:0];
         res.used_height = uh[6:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // predict on acceptance, check on each result strobe
   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         for (int i = 0; i < 64; i++) occ_rows[i] = '0;
         atlas_w = 7'd64;
         atlas_h = 7'd64;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CFG_MAP_WIDTH[0]) atlas_w = csr_wdata;
            else atlas_h = csr_wdata;
         end
         if (start && !busy)
            pending_results.push_back(predict_alloc(req_action, req_rect_x, req_rect_y,
                                                    req_rect_w, req_rect_h));
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_found_x != want.found_x)
                  report_mismatch("found_x", rsp_found_x, want.found_x);
               if (rsp_found_y != want.found_y)
                  report_mismatch("found_y", rsp_found_y, want.found_y);
               if (rsp_used_width != want.used_width)
                  report_mismatch("used_width", rsp_used_width, want.used_width);
               if (rsp_used_height != want.used_height)
                  report_mismatch("used_height", rsp_used_height, want.used_height);
            end
         end
      end
   end

   // send one request, with random gaps between bursts
   task automatic send_request(logic [1:0] act, int x, int y, int w, int h);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock) start = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start = 1'b1;
      req_action = act;
      req_rect_x = x[5:0];
      req_rect_y = y[5:0];
      req_rect_w = w[6:0];
      req_rect_h = h[6:0];
      do @(posedge clock); while (busy);
   endtask

   // drop start and hold until every result is in and the block is idle
   task automatic wait_idle();
      @(negedge clock) start = 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, int value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value[6:0];
      @(negedge clock) csr_wr_en = 1'b0;
   endtask

   task automatic set_map(int w, int h);
      wait_idle();
      write_reg(CFG_MAP_WIDTH[0], w);
      write_reg(CFG_MAP_HEIGHT[0], h);
   endtask

   // empty map after reset, full-size extremes
   task automatic test_empty_map();
      send_request(ACT_EXTENT, 0, 0, 0, 0);
      send_request(ACT_FIND, 0, 0, 64, 64);
      send_request(ACT_FIND, 0, 0, 0, 0);
      send_request(ACT_MARK, 63, 63, 1, 1);
      send_request(ACT_EXTENT, 0, 0, 0, 0);
      send_request(ACT_FIND, 0, 0, 64, 64);
      send_request(ACT_UNMARK, 0, 0, 64, 64);
   endtask

   // out-of-bounds marks and finds, empty rectangles
   task automatic test_bounds();
      send_request(ACT_MARK, 63, 0, 2, 1);
      send_request(ACT_UNMARK, 0, 63, 1, 2);
      send_request(ACT_FIND, 0, 0, 65, 1);
      send_request(ACT_MARK, 10, 10, 0, 5);
      send_request(ACT_MARK, 0, 0, 64, 64);
      send_request(ACT_FIND, 0, 0, 1, 1);
      send_request(ACT_FIND, 0, 0, 0, 3);
      send_request(ACT_UNMARK, 0, 0, 64, 64);
   endtask

   // small map, oversized and zero registers, cells outside the map
   task automatic test_register_extremes();
      set_map(8, 4);
      send_request(ACT_MARK, 0, 0, 3, 2);
      send_request(ACT_FIND, 0, 0, 6, 2);
      send_request(ACT_FIND, 0, 0, 2, 3);
      send_request(ACT_EXTENT, 0, 0, 0, 0);
      set_map(0, 0);
      send_request(ACT_MARK, 0, 0, 0, 0);
      send_request(ACT_FIND, 0, 0, 0, 0);
      send_request(ACT_EXTENT, 0, 0, 0, 0);
      set_map(127, 100);
      send_request(ACT_EXTENT, 0, 0, 0, 0);
      send_request(ACT_UNMARK, 0, 0, 64, 64);
   endtask

   // random phases of well-formed traffic mixed with noise
   task automatic test_random_traffic();
      int mw, mh, sel, x, y, w, h;
      for (int phase = 0; phase < 22; phase++) begin
         if (phase == 10) begin
            mw = 64; mh = 64;
         end else if (phase == 15) begin
            mw = $urandom_range(65, 127); mh = $urandom_range(1, 6);
         end else if (phase == 18) begin
            mw = $urandom_range(1, 6); mh = $urandom_range(65, 127);
         end else if (phase == 20) begin
            mw = 1; mh = 1;
         end else begin
            mw = $urandom_range(1, 16); mh = $urandom_range(1, 16);
         end
         set_map(mw, mh);
         if (mw > 64) mw = 64;
         if (mh > 64) mh = 64;
         for (int n = 0; n < 30; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
               send_request($urandom_range(0, 3), $urandom_range(0, 63),
                            $urandom_range(0, 63), $urandom_range(0, 64),
                            $urandom_range(0, 64));
            end else begin
               x = $urandom_range(0, mw - 1);
               y = $urandom_range(0, mh - 1);
               w = $urandom_range(0, mw - x);
               h = $urandom_range(0, mh - y);
               if (sel < 45) send_request(ACT_MARK, x, y, w, h);
               else if (sel < 62) send_request(ACT_UNMARK, x, y, w, h);
               else if (sel < 88) send_request(ACT_FIND, 0, 0, $urandom_range(0, mw),
                                               $urandom_range(0, mh));
               else send_request(ACT_EXTENT, x, y, w, h);
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait_idle();
      test_empty_map();
      test_bounds();
      test_register_extremes();
      test_random_traffic();
      wait_idle();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #200ms;
      $display("FAIL");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl
rtl/rab_pkg.sv
rtl/rab_row_store.sv
rtl/rect_atlas_bitmap_allocator.sv
rtl/rab_checker.sv
tb/rect_atlas_bitmap_allocator_tb.sv
